/* design/unv_pkg.sv */
// Shared types and constants for the UTF-8 name validator.
package unv_pkg;

  // Verdict codes carried on the result item
  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_EMOJI    = 2'd1,
    CAUSE_ENCODING = 2'd2
  } cause_e;

  // Byte that can open an emoji pair
  typedef enum logic [2:0] {
    PFX_NONE = 3'd0,
    PFX_F0   = 3'd1,
    PFX_C2   = 3'd2,
    PFX_E2   = 3'd3,
    PFX_EE   = 3'd4
  } prefix_e;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 3;   // lead length 0..4
  localparam int unsigned ContW = 2;   // pending continuation bytes

  localparam logic [ByteW-1:0] PairLoF0 = 8'h90;
  localparam logic [ByteW-1:0] PairHiF0 = 8'h9f;
  localparam logic [ByteW-1:0] PairLoC2 = 8'ha9;
  localparam logic [ByteW-1:0] PairHiC2 = 8'hae;
  localparam logic [ByteW-1:0] PairLoE2 = 8'h80;
  localparam logic [ByteW-1:0] PairLoE2b = 8'ha1;
  localparam logic [ByteW-1:0] PairHiE2b = 8'haf;

  // One classified byte, passed from the front to the back
  typedef struct packed {
    prefix_e         prefix;    // this byte as the first of a pair
    logic            hit_9x;    // this byte in 90..9F (after F0 or EE)
    logic            hit_c2;    // this byte in A9..AE (after C2)
    logic            hit_e2;    // this byte in 80..9F or A1..AF (after E2)
    logic [LenW-1:0] lead_len;  // leading ones, at most four
    logic            plain_ok;  // digit, letter or underscore
    logic            cont_ok;   // at least 0x80
    logic            last;
  } unv_item_t;

endpackage

/* design/unv_front.sv */
// Front stage: accepts bytes and classifies each one on its own.
module unv_front import unv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] name_byte_i,
  input  logic             last_byte_i,
  output logic             item_valid_o,
  input  logic             item_taken_i,
  output unv_item_t        item_o
);

  logic      valid_q, valid_d;
  unv_item_t item_q, item_d;
  logic      load;

  // Hold while the classified item waits for the queue
  assign in_stall_o = valid_q && !item_taken_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !item_taken_i);

  // Classify the incoming byte
  always_comb begin
    logic [ByteW-1:0] b;
    b = name_byte_i;
    item_d = '0;
    unique case (b)
      8'hf0:   item_d.prefix = PFX_F0;
      8'hc2:   item_d.prefix = PFX_C2;
      8'he2:   item_d.prefix = PFX_E2;
      8'hee:   item_d.prefix = PFX_EE;
      default: item_d.prefix = PFX_NONE;
    endcase
    item_d.hit_9x = (b >= PairLoF0) && (b <= PairHiF0);
    item_d.hit_c2 = (b >= PairLoC2) && (b <= PairHiC2);
    item_d.hit_e2 = ((b >= PairLoE2) && (b <= PairHiF0)) ||
                    ((b >= PairLoE2b) && (b <= PairHiE2b));
    if (!b[7])      item_d.lead_len = LenW'(0);
    else if (!b[6]) item_d.lead_len = LenW'(1);
    else if (!b[5]) item_d.lead_len = LenW'(2);
    else if (!b[4]) item_d.lead_len = LenW'(3);
    else            item_d.lead_len = LenW'(4);
    item_d.plain_ok = ((b >= 8'h30) && (b <= 8'h39)) ||
                      ((b >= 8'h61) && (b <= 8'h7a)) ||
                      ((b >= 8'h41) && (b <= 8'h5a)) ||
                      (b == 8'h5f);
    item_d.cont_ok = b[7];
    item_d.last    = last_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the classified item on accept
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* design/unv_fifo.sv */
// Two-entry queue of classified items between front and back.
module unv_fifo import unv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_taken_o,
  input  unv_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_i,
  output unv_item_t pop_item_o
);

  unv_item_t   mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  assign push_taken_o = push_valid_i && (count_q != 2'd2);
  assign push         = push_taken_o;
  assign pop          = pop_i && (count_q != 2'd0);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* design/unv_back.sv */
// Back stage: tracks pair and encoding state and registers the verdict.
module unv_back import unv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  output logic      item_pop_o,
  input  unv_item_t item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output logic      name_rejected_o,
  output logic [1:0] reject_cause_o
);

  prefix_e          prev_q, prev_d;
  logic             have_prev_q, have_prev_d;
  logic [ContW-1:0] cont_q, cont_d;
  logic             emoji_q, emoji_d;
  logic             bad_q, bad_d;
  logic             out_valid_q, out_valid_d;
  logic             rejected_q, rejected_d;
  cause_e           cause_q, cause_d;
  logic             out_free, pair_hit;

  // Take an item unless a last byte would overwrite a waiting verdict
  assign out_free   = !out_valid_q || !out_stall_i;
  assign item_pop_o = item_valid_i && (!item_i.last || out_free);

  // Match the previous byte against this one
  always_comb begin
    unique case (prev_q)
      PFX_F0, PFX_EE: pair_hit = item_i.hit_9x;
      PFX_C2:         pair_hit = item_i.hit_c2;
      PFX_E2:         pair_hit = item_i.hit_e2;
      default:        pair_hit = 1'b0;
    endcase
  end

  // Update scan state and form the verdict
  always_comb begin
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    cont_d      = cont_q;
    emoji_d     = emoji_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q && out_stall_i;
    rejected_d  = rejected_q;
    cause_d     = cause_q;
    if (item_pop_o) begin
      emoji_d     = emoji_q || (have_prev_q && pair_hit);
      prev_d      = item_i.prefix;
      have_prev_d = 1'b1;
      if (cont_q == '0) begin
        if (item_i.lead_len == '0) begin
          bad_d = bad_q || !item_i.plain_ok;
        end else begin
          cont_d = ContW'(item_i.lead_len - LenW'(1));
        end
      end else begin
        cont_d = cont_q - ContW'(1);
        bad_d  = bad_q || !item_i.cont_ok;
      end
      if (item_i.last) begin
        out_valid_d = 1'b1;
        if (emoji_d) begin
          rejected_d = 1'b1;
          cause_d    = CAUSE_EMOJI;
        end else if (bad_d) begin
          rejected_d = 1'b1;
          cause_d    = CAUSE_ENCODING;
        end else begin
          rejected_d = 1'b0;
          cause_d    = CAUSE_NONE;
        end
        // Drop scan state for the next name
        prev_d      = PFX_NONE;
        have_prev_d = 1'b0;
        cont_d      = '0;
        emoji_d     = 1'b0;
        bad_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= PFX_NONE;
      have_prev_q <= 1'b0;
      cont_q      <= '0;
      emoji_q     <= 1'b0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
      cont_q      <= cont_d;
      emoji_q     <= emoji_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the verdict payload
  always_ff @(posedge clk_i) begin
    rejected_q <= rejected_d;
    cause_q    <= cause_d;
  end

  assign out_valid_o     = out_valid_q;
  assign name_rejected_o = rejected_q;
  assign reject_cause_o  = cause_q;

endmodule

/* design/utf8_name_validator_core.sv */
// Top level of the UTF-8 name validator: front, queue and back stages.
// Throughput: one byte item per cycle when the output is not stalled.
// A last byte's verdict passes through the front classify register, the two-entry queue
// and then the back verdict register, in that order; a stall can hold it on the way.
// Reset: asynchronous, clears queue, scan state and the output valid.
module utf8_name_validator_core import unv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] name_byte_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             name_rejected_o,
  output logic [1:0]       reject_cause_o
);

  logic      fr_valid, fr_taken;
  unv_item_t fr_item;
  logic      q_valid, q_pop;
  unv_item_t q_item;

  unv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .name_byte_i  (name_byte_i),
    .last_byte_i  (last_byte_i),
    .item_valid_o (fr_valid),
    .item_taken_i (fr_taken),
    .item_o       (fr_item)
  );

  unv_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_taken_o (fr_taken),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_item_o   (q_item)
  );

  unv_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (q_valid),
    .item_pop_o      (q_pop),
    .item_i          (q_item),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .name_rejected_o (name_rejected_o),
    .reject_cause_o  (reject_cause_o)
  );

endmodule

/* design/unv_checker.sv */
// Port-level checks for the UTF-8 name validator, bound to the top level.
module unv_checker import unv_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       name_rejected_o,
  input logic [1:0] reject_cause_o
);

  // A stalled verdict holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(name_rejected_o)
      && $stable(reject_cause_o))
    else $error("stalled verdict changed");

  // Reject flag agrees with the cause
  a_flag_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (name_rejected_o == (reject_cause_o != CAUSE_NONE)))
    else $error("reject flag disagrees with cause");

  // Only defined causes leave the block
  a_cause_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reject_cause_o == CAUSE_NONE || reject_cause_o == CAUSE_EMOJI
      || reject_cause_o == CAUSE_ENCODING))
    else $error("undefined reject cause");

endmodule

bind utf8_name_validator_core unv_checker u_unv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .name_rejected_o (name_rejected_o),
  .reject_cause_o  (reject_cause_o)
);
